>>> rtl/core/tmic_pkg.sv
// shared types and constants for the traffic matrix interval counter
// no dependencies; used by every module of the block but tmic_ram
package tmic_pkg;

  localparam int NODE_W  = 3;
  localparam int BYTES_W = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 48;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  dst;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  tstamp;
  } cmd_t;

endpackage

>>> rtl/core/tmic_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tmic_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/tmic_queue.sv
// short command queue between the front and the back
// depends on tmic_pkg
module tmic_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tmic_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output tmic_pkg::cmd_t head,
  input  logic          pop
);

  tmic_pkg::cmd_t                slots [tmic_pkg::Q_DEPTH];
  logic [tmic_pkg::Q_AW-1:0]     wr_ptr;
  logic [tmic_pkg::Q_AW-1:0]     rd_ptr;
  logic [tmic_pkg::Q_AW:0]       count;

  assign full  = (count == (tmic_pkg::Q_AW+1)'(tmic_pkg::Q_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr        <= wr_ptr + tmic_pkg::Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tmic_pkg::Q_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (tmic_pkg::Q_AW+1)'(1);
        2'b01:   count <= count - (tmic_pkg::Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/tmic_front.sv
// input side: takes beats, drops packets for nodes out of range, queues commands
// depends on tmic_pkg
module tmic_front #(
  parameter int NODES = 8
) (
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [tmic_pkg::NODE_W-1:0]      src_node,
  input  logic [tmic_pkg::NODE_W-1:0]      dst_node,
  input  logic [tmic_pkg::BYTES_W-1:0]     packet_bytes,
  input  logic [tmic_pkg::TIME_W-1:0]      tick_time,
  input  logic                             q_full,
  output logic                             q_push,
  output tmic_pkg::cmd_t                   q_cmd
);

  logic in_range;
  logic keep;

  always_comb begin
    in_range = ({1'b0, src_node} < (tmic_pkg::NODE_W+1)'(NODES)) &&
               ({1'b0, dst_node} < (tmic_pkg::NODE_W+1)'(NODES));
    keep     = (tmic_pkg::kind_t'(kind) == tmic_pkg::KIND_TICK) || in_range;

    in_stall = q_full;
    q_push   = in_valid && !q_full && keep;

    q_cmd.kind   = tmic_pkg::kind_t'(kind);
    q_cmd.src    = src_node;
    q_cmd.dst    = dst_node;
    q_cmd.bytes  = packet_bytes;
    q_cmd.tstamp = tick_time;
  end

endmodule

>>> rtl/core/tmic_back.sv
// execution side: packet read-modify-write on the delta memory and the tick sweep
// depends on tmic_pkg and tmic_ram
module tmic_back #(
  parameter int NODES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tmic_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tmic_pkg::NODE_W-1:0]   rec_src,
  output logic [tmic_pkg::NODE_W-1:0]   rec_dst,
  output logic [tmic_pkg::CNT_W-1:0]    delta_bytes,
  output logic [tmic_pkg::TIME_W-1:0]   rec_time,
  output logic                          last_record
);

  localparam int PAIRS = NODES * NODES;
  localparam int IDX_W = $clog2(PAIRS);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SW_START,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  state_t                          state;

  // packet add stage
  logic                            p2_v;
  logic [IDX_W-1:0]                p2_idx;
  logic [tmic_pkg::BYTES_W-1:0]    p2_bytes;

  // last write, for a read that raced it
  logic                            fw_v;
  logic [IDX_W-1:0]                fw_idx;
  logic [tmic_pkg::CNT_W-1:0]      fw_data;

  // entry holds a nonzero delta; a clear entry reads as zero
  logic [PAIRS-1:0]                nz;

  logic [IDX_W-1:0]                sw_idx;
  logic [tmic_pkg::NODE_W-1:0]     sw_s;
  logic [tmic_pkg::NODE_W-1:0]     sw_d;
  logic [tmic_pkg::TIME_W-1:0]     tick_stamp;

  // record held back until we know whether another one follows
  logic                            pend_v;
  logic [tmic_pkg::NODE_W-1:0]     pend_src;
  logic [tmic_pkg::NODE_W-1:0]     pend_dst;
  logic [tmic_pkg::CNT_W-1:0]      pend_delta;

  logic [IDX_W-1:0]                idx_in;
  logic                            ram_re;
  logic [IDX_W-1:0]                ram_raddr;
  logic [tmic_pkg::CNT_W-1:0]      ram_rdata;
  logic [tmic_pkg::CNT_W-1:0]      operand;
  logic [tmic_pkg::CNT_W-1:0]      sum;
  logic                            ent_nz;
  logic                            sw_last;
  logic                            out_free;
  logic                            sw_adv;

  tmic_ram #(
    .WIDTH (tmic_pkg::CNT_W),
    .DEPTH (PAIRS)
  ) u_delta_ram (
    .clk   (clk),
    .we    (p2_v),
    .waddr (p2_idx),
    .wdata (sum),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_free = !out_valid || !out_stall;
    idx_in   = IDX_W'(int'(q_cmd.src) * NODES + int'(q_cmd.dst));

    if (fw_v && (fw_idx == p2_idx)) begin
      operand = fw_data;
    end else if (nz[p2_idx]) begin
      operand = ram_rdata;
    end else begin
      operand = '0;
    end
    sum = operand + tmic_pkg::CNT_W'(p2_bytes);

    ent_nz  = nz[sw_idx];
    sw_last = (sw_idx == IDX_W'(PAIRS - 1));
    sw_adv  = !(ent_nz && pend_v) || out_free;

    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_in;
    unique case (state)
      ST_RUN: begin
        q_pop  = q_valid;
        ram_re = q_valid && (q_cmd.kind == tmic_pkg::KIND_PACKET);
      end
      ST_SW_START: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_SWEEP: begin
        ram_re    = sw_adv && !sw_last;
        ram_raddr = sw_idx + IDX_W'(1);
      end
      ST_FLUSH: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      p2_v      <= 1'b0;
      fw_v      <= 1'b0;
      nz        <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fw_v    <= p2_v;
      fw_idx  <= p2_idx;
      fw_data <= sum;
      if (p2_v) begin
        nz[p2_idx] <= (sum != '0);
      end
      p2_v <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_RUN: begin
          if (q_valid) begin
            if (q_cmd.kind == tmic_pkg::KIND_PACKET) begin
              p2_v     <= 1'b1;
              p2_idx   <= idx_in;
              p2_bytes <= q_cmd.bytes;
            end else begin
              tick_stamp <= q_cmd.tstamp;
              sw_idx     <= '0;
              sw_s       <= '0;
              sw_d       <= '0;
              state      <= ST_SW_START;
            end
          end
        end
        ST_SW_START: begin
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (sw_adv) begin
            if (ent_nz) begin
              if (pend_v) begin
                out_valid   <= 1'b1;
                rec_src     <= pend_src;
                rec_dst     <= pend_dst;
                delta_bytes <= pend_delta;
                rec_time    <= tick_stamp;
                last_record <= 1'b0;
              end
              pend_v     <= 1'b1;
              pend_src   <= sw_s;
              pend_dst   <= sw_d;
              pend_delta <= ram_rdata;
              nz[sw_idx] <= 1'b0;
            end
            if (sw_last) begin
              state <= ST_FLUSH;
            end else begin
              sw_idx <= sw_idx + IDX_W'(1);
              if (sw_d == tmic_pkg::NODE_W'(NODES - 1)) begin
                sw_d <= '0;
                sw_s <= sw_s + tmic_pkg::NODE_W'(1);
              end else begin
                sw_d <= sw_d + tmic_pkg::NODE_W'(1);
              end
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v) begin
            state <= ST_RUN;
          end else if (out_free) begin
            out_valid   <= 1'b1;
            rec_src     <= pend_src;
            rec_dst     <= pend_dst;
            delta_bytes <= pend_delta;
            rec_time    <= tick_stamp;
            last_record <= 1'b1;
            pend_v      <= 1'b0;
            state       <= ST_RUN;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/core/traffic_matrix_interval_counter_top.sv
// top level of the traffic matrix interval counter
// depends on tmic_pkg, tmic_front, tmic_queue, tmic_back (and tmic_ram below it)

// Keeps, for every ordered (source, destination) pair of NODES nodes, the byte count
// moved since the last tick, in a NODES*NODES x 48-bit memory with one read and one
// write port. A packet beat adds its size to its pair and makes no record; packets
// naming a node at or above NODES are dropped. Packets sustain one beat per cycle
// while no sweep is running: the add reads the memory and writes the sum in the
// next cycle, with a bypass for back-to-back packets to the same pair. A tick beat
// sweeps all pairs, source-major, one entry per cycle through the single read port
// while the output does not stall, and holds the execution side until the sweep is
// done; every nonzero pair gives one record and the last record of a sweep carries
// last_record. A four-entry command queue sits between the input side and the
// execution side, so beats keep being accepted during a sweep until the queue
// fills. Per-entry nonzero flags clear with reset, so the block is usable on the
// first cycle after reset with no memory clearing pass.
module traffic_matrix_interval_counter_top #(
  parameter int NODES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [tmic_pkg::NODE_W-1:0]   src_node,
  input  logic [tmic_pkg::NODE_W-1:0]   dst_node,
  input  logic [tmic_pkg::BYTES_W-1:0]  packet_bytes,
  input  logic [tmic_pkg::TIME_W-1:0]   tick_time,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tmic_pkg::NODE_W-1:0]   rec_src,
  output logic [tmic_pkg::NODE_W-1:0]   rec_dst,
  output logic [tmic_pkg::CNT_W-1:0]    delta_bytes,
  output logic [tmic_pkg::TIME_W-1:0]   rec_time,
  output logic                          last_record
);

  logic           q_full;
  logic           q_push;
  tmic_pkg::cmd_t q_cmd_in;
  logic           q_valid;
  tmic_pkg::cmd_t q_head;
  logic           q_pop;

  tmic_front #(
    .NODES (NODES)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .src_node     (src_node),
    .dst_node     (dst_node),
    .packet_bytes (packet_bytes),
    .tick_time    (tick_time),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd_in)
  );

  tmic_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd_in),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  tmic_back #(
    .NODES (NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rec_src     (rec_src),
    .rec_dst     (rec_dst),
    .delta_bytes (delta_bytes),
    .rec_time    (rec_time),
    .last_record (last_record)
  );

endmodule

>>> rtl/core/tmic_checker.sv
// port-level checks for the traffic matrix interval counter, bound to the top level
// depends on tmic_pkg and traffic_matrix_interval_counter_top
module tmic_checker #(
  parameter int NODES = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tmic_pkg::NODE_W-1:0]   rec_src,
  input logic [tmic_pkg::NODE_W-1:0]   rec_dst,
  input logic [tmic_pkg::CNT_W-1:0]    delta_bytes,
  input logic [tmic_pkg::TIME_W-1:0]   rec_time,
  input logic                          last_record
);

  // an unchanged pair is never reported
  a_delta_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delta_bytes != '0))
    else $error("record with zero byte delta");

  // records only name pairs that exist
  a_pair_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, rec_src} < (tmic_pkg::NODE_W+1)'(NODES)) &&
                   ({1'b0, rec_dst} < (tmic_pkg::NODE_W+1)'(NODES))))
    else $error("record names a node out of range");

  // command queue is empty right after reset, so input is open
  a_open_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_stall)
    else $error("input stalled right after reset");

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(delta_bytes) &&
      $stable(rec_src) && $stable(rec_dst) && $stable(rec_time) &&
      $stable(last_record)))
    else $error("output beat changed while stalled");

endmodule

bind traffic_matrix_interval_counter_top tmic_checker #(
  .NODES (NODES)
) u_tmic_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rec_src     (rec_src),
  .rec_dst     (rec_dst),
  .delta_bytes (delta_bytes),
  .rec_time    (rec_time),
  .last_record (last_record)
);
